[rtl/ukt_pkg.sv]
// Package for the UTF-8 kinsoku tokenizer: token kinds, result and item types,
// the forbidden-at-line-start code point table and the character helpers.
// No dependencies.
package ukt_pkg;

  localparam int unsigned OFFSET_BITS_DEFAULT = 16;
  localparam int unsigned OFS_W               = 16;
  localparam int unsigned RES_FIFO_DEPTH      = 4;
  localparam int unsigned FORBID_N            = 81;

  localparam logic [1:0] KIND_SPACE = 2'd0;
  localparam logic [1:0] KIND_WORD  = 2'd1;
  localparam logic [1:0] KIND_OTHER = 2'd2;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_APOS  = 8'h27;

  typedef struct packed {
    logic       eos;
    logic [7:0] data;
  } ukt_item_t;

  typedef struct packed {
    logic             err;
    logic             done;
    logic [1:0]       kind;
    logic [OFS_W-1:0] tok_end;
    logic [OFS_W-1:0] tok_start;
  } ukt_result_t;

  localparam logic [15:0] FORBID_TAB [FORBID_N] = '{
    16'h002C, 16'h0029, 16'h005D, 16'hFF5D, 16'h3001, 16'h3015, 16'h3009, 16'h300B,
    16'h300D, 16'h300F, 16'h3011, 16'h3019, 16'h3017, 16'h301F, 16'h2019, 16'h201D,
    16'hFF60, 16'h00BB, 16'h309D, 16'h309E, 16'h30FC, 16'h30A1, 16'h30A3, 16'h30A5,
    16'h30A7, 16'h30A9, 16'h30C3, 16'h30E3, 16'h30E5, 16'h30E7, 16'h30EE, 16'h30F5,
    16'h30F6, 16'h3041, 16'h3043, 16'h3045, 16'h3047, 16'h3049, 16'h3063, 16'h3083,
    16'h3085, 16'h3087, 16'h308E, 16'h3095, 16'h3096, 16'h31F0, 16'h31F1, 16'h31F2,
    16'h31F3, 16'h31F4, 16'h31F5, 16'h31F6, 16'h31F7, 16'h31F8, 16'h31F9, 16'h31FA,
    16'h31FB, 16'h31FC, 16'h31FD, 16'h31FE, 16'h31FF, 16'h309A, 16'h3005, 16'h303B,
    16'h2010, 16'h30A0, 16'h2013, 16'h301C, 16'hFF5E, 16'h003F, 16'h0021, 16'h203C,
    16'h2047, 16'h2048, 16'h2049, 16'h30FB, 16'h003A, 16'h003B, 16'h002F, 16'h3002,
    16'h002E
  };

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    if (!b[7])                  len = 3'd1;
    else if (b[7:1] == 7'h7E)   len = 3'd6;
    else if (b[7:2] == 6'h3E)   len = 3'd5;
    else if (b[7:3] == 5'h1E)   len = 3'd4;
    else if (b[7:4] == 4'hE)    len = 3'd3;
    else if (b[7:5] == 3'h6)    len = 3'd2;
    else                        len = 3'd0;
    return len;
  endfunction

  function automatic logic is_word_byte(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A) || (b == CHAR_APOS);
  endfunction

  function automatic logic forbidden_at_start(input logic [2:0] len, input logic [23:0] cb);
    logic [15:0] cp;
    logic        ok;
    logic        hit;
    cp  = '0;
    ok  = 1'b0;
    hit = 1'b0;
    case (len)
      3'd1: begin
        cp = {8'h00, cb[7:0]};
        ok = !cb[7];
      end
      3'd2: begin
        cp = {5'b0, cb[12:8], cb[5:0]};
        ok = (cb[7:6] == 2'b10) && (cp >= 16'h0080);
      end
      3'd3: begin
        cp = {cb[19:16], cb[13:8], cb[5:0]};
        ok = (cb[15:14] == 2'b10) && (cb[7:6] == 2'b10) && (cp >= 16'h0800);
      end
      default: ok = 1'b0;
    endcase
    for (int i = 0; i < FORBID_N; i++) begin
      if (FORBID_TAB[i] == cp) hit = 1'b1;
    end
    return ok && hit;
  endfunction

endpackage

[rtl/ukt_in_stage.sv]
// Input register of the tokenizer: holds one byte transaction until the
// tokenizer takes it. Depends on ukt_pkg.
module ukt_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  ukt_pkg::ukt_item_t item_i,
  output logic              valid_o,
  output ukt_pkg::ukt_item_t item_o,
  input  logic              take_i
);
  import ukt_pkg::*;

  logic      valid_q;
  ukt_item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

[rtl/ukt_step.sv]
// Tokenizer state and per-byte step: character assembly, token runs, kinsoku
// extension and fault handling; emits up to two results per byte. Depends on ukt_pkg.
module ukt_step #(
  parameter int unsigned OFFSET_BITS = ukt_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  ukt_pkg::ukt_item_t   item_i,
  input  logic                 space_ok_i,
  output logic                 take_o,
  output logic [1:0]           push_cnt_o,
  output ukt_pkg::ukt_result_t res0_o,
  output ukt_pkg::ukt_result_t res1_o
);
  import ukt_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RUN  = 2'd1,
    PH_TAIL = 2'd2
  } phase_e;

  localparam logic [OFFSET_BITS-1:0] POS_LIMIT = {OFFSET_BITS{1'b1}};

  phase_e                 phase_q, phase_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [1:0]             kind_q, kind_d;
  logic [23:0]            cb_q, cb_d;
  logic [2:0]             cl_q, cl_d;
  logic [2:0]             rem_q, rem_d;
  logic                   disc_q, disc_d;

  logic                   take;
  logic                   clear_str;
  logic                   fault;
  logic [23:0]            cb;
  logic [2:0]             cl;
  logic [2:0]             rem;
  logic [2:0]             len;
  logic [OFFSET_BITS-1:0] pos_n;
  logic [OFFSET_BITS-1:0] cs;
  logic [7:0]             lb;
  logic                   open;
  phase_e                 ph;
  logic [OFFSET_BITS-1:0] st;
  logic [1:0]             kd;
  logic [1:0]             cnt;
  ukt_result_t            res0, res1, fin;

  function automatic logic [OFS_W-1:0] to_ofs(input logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+OFS_W-1:0] ext;
    ext = {{OFS_W{1'b0}}, v};
    return ext[OFS_W-1:0];
  endfunction

  function automatic ukt_result_t mk_res(input logic [OFFSET_BITS-1:0] s,
                                         input logic [OFFSET_BITS-1:0] e,
                                         input logic [1:0] k, input logic d,
                                         input logic er);
    ukt_result_t r;
    r.err       = er;
    r.done      = d;
    r.kind      = k;
    r.tok_end   = to_ofs(e);
    r.tok_start = to_ofs(s);
    return r;
  endfunction

  assign take       = valid_i && space_ok_i;
  assign take_o     = take;
  assign push_cnt_o = cnt;
  assign res0_o     = res0;
  assign res1_o     = res1;

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    start_d   = start_q;
    kind_d    = kind_q;
    cb_d      = cb_q;
    cl_d      = cl_q;
    rem_d     = rem_q;
    disc_d    = disc_q;
    clear_str = 1'b0;
    fault     = 1'b0;
    cb        = cb_q;
    cl        = cl_q;
    rem       = rem_q;
    len       = lead_length(item_i.data);
    pos_n     = pos_q + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
    cs        = '0;
    lb        = '0;
    open      = 1'b0;
    ph        = phase_q;
    st        = start_q;
    kd        = kind_q;
    cnt       = 2'd0;
    res0      = '0;
    res1      = '0;
    fin       = '0;
    if (take) begin
      if (disc_q) begin
        if (item_i.data == 8'h00 || item_i.eos) begin
          disc_d    = 1'b0;
          clear_str = 1'b1;
        end
      end else if (rem_q == 3'd0 && item_i.data == 8'h00) begin
        if (phase_q != PH_IDLE) begin
          res0 = mk_res(start_q, pos_q, kind_q, 1'b1, 1'b0);
          cnt  = 2'd1;
        end
        clear_str = 1'b1;
      end else begin
        if (pos_q == POS_LIMIT) begin
          fault = 1'b1;
        end else if (rem_q == 3'd0) begin
          if (len == 3'd0) begin
            fault = 1'b1;
          end else begin
            cb  = {16'h0000, item_i.data};
            cl  = len;
            rem = len - 3'd1;
          end
        end else begin
          if ((cl_q - rem_q) < 3'd3) cb = {cb_q[15:0], item_i.data};
          rem = rem_q - 3'd1;
        end
        if (!fault && rem != 3'd0 && item_i.eos) fault = 1'b1;
        if (fault) begin
          res0      = mk_res(pos_q, pos_q, KIND_SPACE, 1'b1, 1'b1);
          cnt       = 2'd1;
          clear_str = 1'b1;
          disc_d    = !item_i.eos;
        end else begin
          pos_d = pos_n;
          cb_d  = cb;
          cl_d  = cl;
          rem_d = rem;
          if (rem == 3'd0) begin
            cs = pos_n - {{(OFFSET_BITS-3){1'b0}}, cl};
            lb = cb[7:0];
            if (phase_q == PH_IDLE) begin
              open = 1'b1;
            end else if (phase_q == PH_RUN && cl == 3'd1 &&
                         ((kind_q == KIND_SPACE && lb == CHAR_SPACE) ||
                          (kind_q == KIND_WORD && is_word_byte(lb)))) begin
              ph = phase_q;
            end else if (forbidden_at_start(cl, cb)) begin
              ph = PH_TAIL;
            end else begin
              res0 = mk_res(start_q, cs, kind_q, 1'b0, 1'b0);
              cnt  = 2'd1;
              open = 1'b1;
            end
            if (open) begin
              st = cs;
              if (cl == 3'd1 && lb == CHAR_SPACE) begin
                kd = KIND_SPACE;
                ph = PH_RUN;
              end else if (cl == 3'd1 && is_word_byte(lb)) begin
                kd = KIND_WORD;
                ph = PH_RUN;
              end else begin
                kd = KIND_OTHER;
                ph = PH_TAIL;
              end
            end
            phase_d = ph;
            start_d = st;
            kind_d  = kd;
            if (item_i.eos) begin
              fin = mk_res(st, pos_n, kd, 1'b1, 1'b0);
              if (cnt == 2'd0) res0 = fin;
              else             res1 = fin;
              cnt       = cnt + 2'd1;
              clear_str = 1'b1;
            end
          end
        end
      end
      if (clear_str) begin
        phase_d = PH_IDLE;
        pos_d   = '0;
        start_d = '0;
        kind_d  = KIND_SPACE;
        cb_d    = '0;
        cl_d    = '0;
        rem_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      kind_q  <= KIND_SPACE;
      cb_q    <= '0;
      cl_q    <= '0;
      rem_q   <= '0;
      disc_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      kind_q  <= kind_d;
      cb_q    <= cb_d;
      cl_q    <= cl_d;
      rem_q   <= rem_d;
      disc_q  <= disc_d;
    end
  end

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt != 2'd0 && res0.err) |-> (cnt == 2'd1 && res0.done))
    else $error("error result not alone or not final");

  a_discard_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && disc_q) |-> (cnt == 2'd0))
    else $error("result produced while dropping a string");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt == 2'd2) |-> (!res0.done && res1.done && !res1.err))
    else $error("bad result pair");

  a_fault_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt != 2'd0 && res0.err && !item_i.eos) |=> disc_q)
    else $error("fault without drop of the string tail");

endmodule

[rtl/ukt_result_fifo.sv]
// Result queue of the tokenizer: takes up to two results per cycle and
// delivers one per cycle while ready_i is high. Depends on ukt_pkg.
module ukt_result_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           push_cnt_i,
  input  ukt_pkg::ukt_result_t res0_i,
  input  ukt_pkg::ukt_result_t res1_i,
  output logic                 space_ok_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output ukt_pkg::ukt_result_t res_o
);
  import ukt_pkg::*;

  localparam int unsigned PTR_W = $clog2(RES_FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(RES_FIFO_DEPTH + 1);

  ukt_result_t      mem_q [RES_FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d;
  logic [PTR_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PTR_W-1:0] wr_nx;
  logic             pop;

  assign valid_o    = cnt_q != '0;
  assign pop        = valid_o && ready_i;
  assign res_o      = mem_q[rd_q];
  assign space_ok_o = cnt_q <= CNT_W'(RES_FIFO_DEPTH - 2);
  assign wr_nx      = wr_q + PTR_W'(1);
  assign wr_d       = wr_q + PTR_W'(push_cnt_i);
  assign rd_d       = rd_q + PTR_W'(pop);
  assign cnt_d      = cnt_q + CNT_W'(push_cnt_i) - CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wr_q] <= res0_i;
    if (push_cnt_i == 2'd2) mem_q[wr_nx] <= res1_i;
  end

endmodule

[rtl/utf8_kinsoku_tokenizer.sv]
// Top level of the UTF-8 kinsoku tokenizer: input register, tokenizer step and
// result queue. Depends on ukt_pkg, ukt_in_stage, ukt_step, ukt_result_fifo.
//
//  channel  | direction | tdata                  | tlast         | tuser
//  s_axis   | in        | data_byte              | end_of_string | -
//  m_axis   | out       | token_start, token_end | string_done   | token_kind, error_flag
//
// One byte transaction per cycle is taken while the result queue has room; each
// byte is processed combinationally between the input register and the result queue.
// A byte yields zero, one or two results; the queue drains one result per cycle
// while m_axis_tready is high, so two results from one byte leave as two transfers.
// s_axis_tready drops while a byte waits in the input register and the result
// queue has fewer than two free entries.
// Reset clears the control state at once; no clearing pass.
module utf8_kinsoku_tokenizer #(
  parameter int unsigned OFFSET_BITS = ukt_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_string
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] token_start, [31:16] token_end
  output logic        m_axis_tlast,   // string_done
  output logic [2:0]  m_axis_tuser    // [1:0] token_kind, [2] error_flag
);
  import ukt_pkg::*;

  ukt_item_t   in_item;
  ukt_item_t   reg_item;
  logic        reg_valid;
  logic        take;
  logic        space_ok;
  logic [1:0]  push_cnt;
  ukt_result_t res0, res1, res_out;

  assign in_item.data = s_axis_tdata;
  assign in_item.eos  = s_axis_tlast;

  ukt_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (reg_valid),
    .item_o  (reg_item),
    .take_i  (take)
  );

  ukt_step #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (reg_valid),
    .item_i     (reg_item),
    .space_ok_i (space_ok),
    .take_o     (take),
    .push_cnt_o (push_cnt),
    .res0_o     (res0),
    .res1_o     (res1)
  );

  ukt_result_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .res0_i     (res0),
    .res1_i     (res1),
    .space_ok_o (space_ok),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .res_o      (res_out)
  );

  assign m_axis_tdata = {res_out.tok_end, res_out.tok_start};
  assign m_axis_tlast = res_out.done;
  assign m_axis_tuser = {res_out.err, res_out.kind};

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for utf8_kinsoku_tokenizer: streams UTF-8 strings byte by byte,
// predicts every token report and compares each one on the result stream.
// Depends on ukt_pkg and the tokenizer RTL.
module tb_top;
  import ukt_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [15:0] OFS_LAST = 16'hFFFF;

  localparam int unsigned NO_START_CP [81] = '{
    'h002C, 'h0029, 'h005D, 'hFF5D, 'h3001, 'h3015, 'h3009, 'h300B, 'h300D,
    'h300F, 'h3011, 'h3019, 'h3017, 'h301F, 'h2019, 'h201D, 'hFF60, 'h00BB,
    'h309D, 'h309E, 'h30FC, 'h30A1, 'h30A3, 'h30A5, 'h30A7, 'h30A9, 'h30C3,
    'h30E3, 'h30E5, 'h30E7, 'h30EE, 'h30F5, 'h30F6, 'h3041, 'h3043, 'h3045,
    'h3047, 'h3049, 'h3063, 'h3083, 'h3085, 'h3087, 'h308E, 'h3095, 'h3096,
    'h31F0, 'h31F1, 'h31F2, 'h31F3, 'h31F4, 'h31F5, 'h31F6, 'h31F7, 'h31F8,
    'h31F9, 'h31FA, 'h31FB, 'h31FC, 'h31FD, 'h31FE, 'h31FF, 'h309A, 'h3005,
    'h303B, 'h2010, 'h30A0, 'h2013, 'h301C, 'hFF5E, 'h003F, 'h0021, 'h203C,
    'h2047, 'h2048, 'h2049, 'h30FB, 'h003A, 'h003B, 'h002F, 'h3002, 'h002E
  };

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_RUN, SCAN_TAIL} scan_phase_e;
  typedef enum int {END_ON_EOS, END_ON_ZERO, END_ON_ZERO_EOS} str_end_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic        s_axis_tlast = 1'b0;    // end_of_string
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // [15:0] token_start, [31:16] token_end
  logic        m_axis_tlast;           // string_done
  logic [2:0]  m_axis_tuser;           // [1:0] token_kind, [2] error_flag

  ukt_item_t   bytes_pending [$];
  ukt_result_t tokens_due [$];
  ukt_item_t   next_item;
  ukt_result_t want;
  logic [8:0]  opening [$];

  scan_phase_e scan_phase = SCAN_IDLE;
  logic [15:0] byte_ofs = '0;
  logic [15:0] tok_start = '0;
  logic [1:0]  tok_kind = KIND_SPACE;
  logic [23:0] chr_bytes = '0;
  logic [2:0]  chr_len = '0;
  logic [2:0]  chr_left = '0;
  logic        dropping = 1'b0;

  int tx_idle_pct = 15;
  int rx_idle_pct = 46;
  int rx_hold_left = 0;
  bit rx_hold_req = 1'b0;
  bit rx_hold_taken = 1'b0;
  int cycle_count = 0;
  int mismatches = 0;
  int tokens_checked = 0;
  int fault_reports = 0;
  int bytes_queued = 0;
  int strings_queued = 0;

  utf8_kinsoku_tokenizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [2:0] char_len_of(input logic [7:0] b);
    casez (b)
      8'b0???????: return 3'd1;
      8'b110?????: return 3'd2;
      8'b1110????: return 3'd3;
      8'b11110???: return 3'd4;
      8'b111110??: return 3'd5;
      8'b1111110?: return 3'd6;
      default:     return 3'd0;
    endcase
  endfunction

  function automatic bit is_word_char(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A) || b == CHAR_APOS;
  endfunction

  function automatic bit no_line_start();
    int unsigned cp;
    bit legal;
    cp = 0;
    legal = 1'b0;
    case (chr_len)
      3'd1: begin
        cp = chr_bytes[7:0];
        legal = 1'b1;
      end
      3'd2: begin
        cp = {chr_bytes[12:8], chr_bytes[5:0]};
        legal = chr_bytes[7:6] == 2'b10 && cp >= 'h80;
      end
      3'd3: begin
        cp = {chr_bytes[19:16], chr_bytes[13:8], chr_bytes[5:0]};
        legal = chr_bytes[15:14] == 2'b10 && chr_bytes[7:6] == 2'b10 && cp >= 'h800;
      end
      default: legal = 1'b0;
    endcase
    if (!legal) return 1'b0;
    foreach (NO_START_CP[i]) begin
      if (NO_START_CP[i] == cp) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void push_token(input logic [15:0] s, input logic [15:0] e,
                                     input logic [1:0] kind, input logic done,
                                     input logic err);
    ukt_result_t r;
    r.tok_start = s;
    r.tok_end = e;
    r.kind = kind;
    r.done = done;
    r.err = err;
    tokens_due.push_back(r);
    if (err) fault_reports++;
  endfunction

  function automatic void restart_string();
    scan_phase = SCAN_IDLE;
    byte_ofs = '0;
    tok_start = '0;
    tok_kind = KIND_SPACE;
    chr_bytes = '0;
    chr_len = '0;
    chr_left = '0;
  endfunction

  function automatic void raise_fault(input logic eos);
    push_token(byte_ofs, byte_ofs, KIND_SPACE, 1'b1, 1'b1);
    restart_string();
    dropping = !eos;
  endfunction

  function automatic void open_tok(input logic [15:0] at);
    tok_start = at;
    if (chr_len == 3'd1 && chr_bytes[7:0] == CHAR_SPACE) begin
      tok_kind = KIND_SPACE;
      scan_phase = SCAN_RUN;
    end else if (chr_len == 3'd1 && is_word_char(chr_bytes[7:0])) begin
      tok_kind = KIND_WORD;
      scan_phase = SCAN_RUN;
    end else begin
      tok_kind = KIND_OTHER;
      scan_phase = SCAN_TAIL;
    end
  endfunction

  function automatic void finish_char();
    logic [15:0] cs;
    cs = byte_ofs - chr_len;
    if (scan_phase == SCAN_IDLE) begin
      open_tok(cs);
      return;
    end
    if (scan_phase == SCAN_RUN && chr_len == 3'd1) begin
      if (tok_kind == KIND_SPACE && chr_bytes[7:0] == CHAR_SPACE) return;
      if (tok_kind == KIND_WORD && is_word_char(chr_bytes[7:0])) return;
    end
    if (no_line_start()) begin
      scan_phase = SCAN_TAIL;
      return;
    end
    push_token(tok_start, cs, tok_kind, 1'b0, 1'b0);
    open_tok(cs);
  endfunction

  function automatic void tokenize_byte(input logic [7:0] b, input logic eos);
    logic [2:0] len;
    if (dropping) begin
      if (b == 8'h00 || eos) begin
        dropping = 1'b0;
        restart_string();
      end
      return;
    end
    if (chr_left == 3'd0 && b == 8'h00) begin
      if (scan_phase != SCAN_IDLE) push_token(tok_start, byte_ofs, tok_kind, 1'b1, 1'b0);
      restart_string();
      return;
    end
    if (byte_ofs >= OFS_LAST) begin
      raise_fault(eos);
      return;
    end
    if (chr_left == 3'd0) begin
      len = char_len_of(b);
      if (len == 3'd0) begin
        raise_fault(eos);
        return;
      end
      chr_bytes = {16'h0000, b};
      chr_len = len;
      chr_left = len - 3'd1;
    end else begin
      if (chr_len - chr_left < 3) chr_bytes = {chr_bytes[15:0], b};
      chr_left = chr_left - 3'd1;
    end
    if (chr_left != 3'd0 && eos) begin
      raise_fault(eos);
      return;
    end
    byte_ofs = byte_ofs + 16'd1;
    if (chr_left == 3'd0) begin
      finish_char();
      if (eos) begin
        push_token(tok_start, byte_ofs, tok_kind, 1'b1, 1'b0);
        restart_string();
      end
    end
  endfunction

  function automatic void report_token(input string why, input ukt_result_t exp_tok);
    mismatches++;
    if (mismatches <= 10) begin
      $display("Token mismatch (%s) at cycle %0d", why, cycle_count);
      $display("  expected start %0d end %0d kind %0d done %0b err %0b",
               exp_tok.tok_start, exp_tok.tok_end, exp_tok.kind, exp_tok.done, exp_tok.err);
      $display("  actual   start %0d end %0d kind %0d done %0b err %0b",
               m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser[1:0], m_axis_tlast,
               m_axis_tuser[2]);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= 8'h00;
      s_axis_tlast <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) tokenize_byte(s_axis_tdata, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (bytes_pending.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          next_item = bytes_pending.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= next_item.data;
          s_axis_tlast <= next_item.eos;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_hold_left <= 0;
      rx_hold_taken <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        tokens_checked++;
        if (tokens_due.size() == 0) begin
          report_token("nothing due", '0);
        end else begin
          want = tokens_due.pop_front();
          if (m_axis_tdata[15:0] !== want.tok_start || m_axis_tdata[31:16] !== want.tok_end ||
              m_axis_tuser[1:0] !== want.kind || m_axis_tlast !== want.done ||
              m_axis_tuser[2] !== want.err)
            report_token("field", want);
        end
      end
      if (rx_hold_left != 0) begin
        rx_hold_left <= rx_hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (rx_hold_req && !rx_hold_taken) begin
        rx_hold_left <= 400;
        rx_hold_taken <= 1'b1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= $urandom_range(0, 99) >= rx_idle_pct;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d tokens outstanding",
               cycle_count, tokens_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] b, input logic eos);
    ukt_item_t it;
    it.data = b;
    it.eos = eos;
    bytes_pending.push_back(it);
    bytes_queued++;
  endtask

  // Emit the first keep bytes of an nb-byte encoding of cp; overlong forms allowed.
  task automatic add_char(input int unsigned cp, input int nb, input int keep,
                          input logic last);
    logic [7:0] b;
    logic [7:0] pre;
    for (int k = 0; k < keep; k++) begin
      if (nb == 1) begin
        b = 8'(cp & 'h7F);
      end else if (k == 0) begin
        pre = 8'hFF << (8 - nb);
        b = pre | 8'((cp >> (6 * (nb - 1))) & ('h7F >> nb));
      end else begin
        b = 8'h80 | 8'((cp >> (6 * (nb - 1 - k))) & 'h3F);
      end
      add_byte(b, last && k == keep - 1);
    end
  endtask

  function automatic int utf8_len(input int unsigned cp);
    return cp < 'h80 ? 1 : (cp < 'h800 ? 2 : 3);
  endfunction

  function automatic int unsigned word_char();
    int sel;
    sel = $urandom_range(0, 62);
    if (sel < 10) return 'h30 + sel;
    if (sel < 36) return 'h41 + sel - 10;
    if (sel < 62) return 'h61 + sel - 36;
    return CHAR_APOS;
  endfunction

  function automatic int unsigned forbid_ascii();
    int unsigned cp;
    cp = 'hFFFF;
    while (cp >= 'h80) cp = NO_START_CP[$urandom_range(0, 80)];
    return cp;
  endfunction

  task automatic add_random_string(input bit noisy);
    int nchars;
    int sel;
    int nb;
    int unsigned cp;
    str_end_e how;
    logic last;
    nchars = $urandom_range(1, 12);
    sel = $urandom_range(0, 19);
    how = sel < 9 ? END_ON_EOS : (sel < 18 ? END_ON_ZERO : END_ON_ZERO_EOS);
    strings_queued++;
    for (int i = 0; i < nchars; i++) begin
      last = i == nchars - 1 && how == END_ON_EOS;
      sel = $urandom_range(0, noisy ? 99 : 91);
      nb = 1;
      cp = 0;
      if (sel < 22) begin
        cp = CHAR_SPACE;
      end else if (sel < 50) begin
        cp = word_char();
      end else if (sel < 56) begin
        cp = forbid_ascii();
      end else if (sel < 68) begin
        cp = NO_START_CP[$urandom_range(0, 80)];
        nb = utf8_len(cp);
      end else if (sel < 74) begin
        cp = $urandom_range(1, 127);
      end else if (sel < 80) begin
        cp = $urandom_range(128, 'hFFFF);
        nb = utf8_len(cp);
      end else if (sel < 84) begin
        cp = NO_START_CP[$urandom_range(0, 80)];
        nb = utf8_len(cp) + 1;
      end else if (sel < 88) begin
        cp = $urandom;
        nb = $urandom_range(4, 6);
      end
      if (sel < 88) begin
        add_char(cp, nb, nb, last);
      end else if (sel < 92) begin
        add_byte(8'hE0 | 8'($urandom_range(0, 15)), 1'b0);
        add_byte(8'($urandom), 1'b0);
        add_byte(8'($urandom), last);
      end else if (sel < 96) begin
        sel = $urandom_range(0, 65);
        add_byte(sel < 64 ? (8'h80 | 8'(sel)) : (sel == 64 ? 8'hFE : 8'hFF), last);
      end else begin
        nb = $urandom_range(2, 6);
        add_char($urandom, nb, $urandom_range(1, nb - 1), 1'b1);
        return;
      end
    end
    if (how == END_ON_ZERO) add_byte(8'h00, 1'b0);
    if (how == END_ON_ZERO_EOS) add_byte(8'h00, 1'b1);
  endtask

  task automatic fill_random(input int count);
    int target;
    target = bytes_queued + count;
    while (bytes_queued < target) add_random_string($urandom_range(0, 4) == 0);
  endtask

  task automatic wait_drained();
    while (bytes_pending.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    while (tokens_due.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    opening = '{9'h000,
                9'h020, 9'h020, 9'h041, 9'h027, 9'h039, 9'h02C, 9'h0E3, 9'h080,
                9'h081, 9'h0C2, 9'h0BB, 9'h100,
                9'h0FC, 9'h080, 9'h080, 9'h080, 9'h080, 9'h0BF, 9'h0E3, 9'h000,
                9'h080, 9'h17F,
                9'h080, 9'h071, 9'h000,
                9'h0E3, 9'h181,
                9'h1FE, 9'h0FF, 9'h141};
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (opening[i]) add_byte(opening[i][7:0], opening[i][8]);
    strings_queued += 7;
    wait_drained();

    rx_hold_req = 1'b1;
    fill_random(305);
    wait_drained();

    tx_idle_pct = 46;
    rx_idle_pct = 15;
    fill_random(305);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    fill_random(305);
    wait_drained();
    repeat (20) @(negedge clk_i);

    $display("Run sent %0d bytes in %0d strings and checked %0d tokens, %0d of them faults.",
             bytes_queued, strings_queued, tokens_checked, fault_reports);
    $display("It covered three idle mixes, a long output stall, bad leads and cut characters.");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
